// ===== design/merkle_root_sdbm_hex_top_assert.svh =====
// Assertion macros for the merkle root block.
`ifndef MERKLE_ROOT_SDBM_HEX_TOP_ASSERT_SVH
`define MERKLE_ROOT_SDBM_HEX_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define MRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/mrs_pkg.sv =====
// Package for the merkle root block: payload types, codes and states.
`timescale 1ns / 1ps
`default_nettype none
package mrs_pkg;
    localparam int MaxLeavesDefault = 256;

    typedef enum logic [1:0] {
        ACT_BYTE   = 2'd0,
        ACT_CLOSE  = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] root_hash;
        logic        empty_set;
        logic        overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_A,
        ST_READ_B,
        ST_HEX_A,
        ST_HEX_B,
        ST_WRITE,
        ST_ROOT,
        ST_OUT
    } t_state;

    function automatic logic [31:0] sdbm_char(input logic [31:0] h, input logic [7:0] c);
        sdbm_char = {24'd0, c} + (h << 6) + (h << 16) - h;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
    endfunction

    // Index of the top nonzero nibble, zero when the value is zero.
    function automatic logic [2:0] top_nibble(input logic [31:0] v);
        logic [2:0] t;
        t = 3'd0;
        for (int k = 1; k < 8; k++) begin
            if (v[4*k +: 4] != 4'd0) t = 3'(k);
        end
        top_nibble = t;
    endfunction
endpackage
`default_nettype wire

// ===== design/merkle_root_sdbm_hex_top.sv =====
// Top level of the merkle root block over sdbm-hashed leaves.
//
// Input channel: each item carries an action and a byte, one item per
// cycle while o_stall is low. Bytes (action 0) fold into the open leaf
// hash, close (1) stores the leaf hash into the node memory, finish (2)
// reduces the memory to a root and emits one output item; action 3 is
// ignored. Byte and close items are taken back to back.
// Finish walks the node memory through one read/write port: for each
// pair it reads both children, folds the hex digits of each child (1..8
// each) into the pair hash and writes the parent, over all levels (about
// N parents for N leaves), then reads the root and emits it.
// No input item is taken while a finish is in progress or its result waits.
// The output register holds the item while i_stall is high.
// Reset clears counts, running hash and flags; the memory is not cleared
// and needs no clearing pass, since only written entries are used.
`timescale 1ns / 1ps
`default_nettype none
module merkle_root_sdbm_hex_top #(
    parameter int MAX_LEAVES = mrs_pkg::MaxLeavesDefault
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  mrs_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  wire                i_stall,
    output mrs_pkg::t_out_item o_data
);
    import mrs_pkg::*;
    `include "merkle_root_sdbm_hex_top_assert.svh"

    localparam int AW = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
    localparam int CW = $clog2(MAX_LEAVES + 1);

    logic [31:0] r_mem [MAX_LEAVES];
    logic [31:0] r_rdata;

    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [31:0] r_hash, n_hash;
    logic        r_zero, n_zero;
    logic        r_ovf, n_ovf;
    logic [CW-1:0] r_n, n_n;     // entries in current level
    logic [CW-1:0] r_i, n_i;     // read index
    logic [CW-1:0] r_m, n_m;     // write index
    logic [31:0] r_a, n_a;
    logic [31:0] r_b, n_b;
    logic [31:0] r_ph, n_ph;     // pair hash in progress
    logic [2:0]  r_k, n_k;       // nibble index
    logic        r_valid, n_valid;
    t_out_item   r_out, n_out;

    logic        in_acc;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0] mem_wdata;

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE) || r_valid;
    assign o_valid = r_valid;
    assign o_data  = r_out;

    // Node memory: one port, registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_data.action == ACT_FINISH) begin
                    n_state = (r_count > CW'(1)) ? ST_READ_A : ST_ROOT;
                end
            end
            ST_READ_A: n_state = ST_READ_B;
            ST_READ_B: n_state = ST_HEX_A;
            ST_HEX_A:  n_state = (r_k == 3'd0) ? ST_HEX_B : ST_HEX_A;
            ST_HEX_B:  n_state = (r_k == 3'd0) ? ST_WRITE : ST_HEX_B;
            ST_WRITE: begin
                if (r_i + CW'(2) < r_n) n_state = ST_READ_A;
                else if (r_m != '0) n_state = ST_READ_A;
                else n_state = ST_ROOT;
            end
            ST_ROOT:   n_state = ST_OUT;
            ST_OUT:    n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_count = r_count;
        n_hash  = r_hash;
        n_zero  = r_zero;
        n_ovf   = r_ovf;
        n_n     = r_n;
        n_i     = r_i;
        n_m     = r_m;
        n_a     = r_a;
        n_b     = r_b;
        n_ph    = r_ph;
        n_k     = r_k;
        n_valid = r_valid;
        n_out   = r_out;
        mem_we    = 1'b0;
        mem_addr  = r_i[AW-1:0];
        mem_wdata = r_ph;
        if (r_valid && !i_stall) n_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                mem_addr  = r_count[AW-1:0];
                mem_wdata = r_hash;
                if (in_acc) begin
                    priority case (i_data.action)
                        ACT_BYTE: begin
                            if (!r_zero) begin
                                if (i_data.data_byte == 8'd0) n_zero = 1'b1;
                                else n_hash = sdbm_char(r_hash, i_data.data_byte);
                            end
                        end
                        ACT_CLOSE: begin
                            if (r_count < CW'(MAX_LEAVES)) begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                            n_hash = '0;
                            n_zero = 1'b0;
                        end
                        ACT_FINISH: begin
                            n_n = r_count;
                            n_i = '0;
                            n_m = '0;
                            mem_addr = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ_A: begin
                // Issue the read of a at the read index.
            end
            ST_READ_B: begin
                // Data for a arrives now; issue the b read (a again past the end).
                mem_addr = (r_i + CW'(1) < r_n) ? AW'(r_i + CW'(1)) : r_i[AW-1:0];
                n_a  = r_rdata;
                n_k  = top_nibble(r_rdata);
                n_ph = '0;
            end
            ST_HEX_A: begin
                if (r_k == top_nibble(r_a)) n_b = (r_i + CW'(1) < r_n) ? r_rdata : r_a;
                n_ph = sdbm_char(r_ph, hex_char(r_a[{r_k, 2'b00} +: 4]));
                if (r_k == 3'd0) n_k = top_nibble(n_b);
                else n_k = r_k - 3'd1;
            end
            ST_HEX_B: begin
                n_ph = sdbm_char(r_ph, hex_char(r_b[{r_k, 2'b00} +: 4]));
                if (r_k != 3'd0) n_k = r_k - 3'd1;
            end
            ST_WRITE: begin
                mem_we   = 1'b1;
                mem_addr = r_m[AW-1:0];
                n_m = r_m + CW'(1);
                n_i = r_i + CW'(2);
                if (r_i + CW'(2) >= r_n) begin
                    n_n = r_m + CW'(1);
                    n_i = '0;
                    n_m = '0;
                end
            end
            ST_ROOT: begin
                mem_addr = '0;
            end
            ST_OUT: begin
                n_valid = 1'b1;
                n_out.root_hash = (r_count == '0) ? 32'd0 : r_rdata;
                n_out.empty_set = (r_count == '0);
                n_out.overflow  = r_ovf;
                n_count = '0;
                n_hash  = '0;
                n_zero  = 1'b0;
                n_ovf   = 1'b0;
            end
            default: ;
        endcase
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_hash  <= '0;
            r_zero  <= 1'b0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_hash  <= n_hash;
            r_zero  <= n_zero;
            r_ovf   <= n_ovf;
            r_valid <= n_valid;
        end
        r_n   <= n_n;
        r_i   <= n_i;
        r_m   <= n_m;
        r_a   <= n_a;
        r_b   <= n_b;
        r_ph  <= n_ph;
        r_k   <= n_k;
        r_out <= n_out;
    end

    `MRS_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != ST_IDLE, o_stall, "busy but ready")
    `MRS_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_LEAVES), "count over cap")
    `MRS_ASSERT_NEXT(a_out_follows, i_clk, i_rst_n, r_state == ST_OUT, r_valid && r_state == ST_IDLE, "no result after finish")
    `MRS_ASSERT_NEXT(a_clear_after, i_clk, i_rst_n, r_state == ST_OUT, r_count == '0 && !r_ovf, "set not cleared")
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the merkle root block: directed and random leaf sets against a predictor.
`timescale 1ns / 1ps
module tb_top;
    import mrs_pkg::*;

    localparam int Leaves = 256;
    localparam int CycleLimit = 4000000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    merkle_root_sdbm_hex_top #(.MAX_LEAVES(Leaves)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_data(in_item),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_item)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state
    logic [31:0] leaf_hashes [Leaves];
    int unsigned stored_leaves = 0;
    logic [31:0] open_hash = '0;
    logic        open_terminated = 1'b0;
    logic        dropped_leaf = 1'b0;
    t_out_item   root_queue [$];

    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned hold_cycles = 0;
    bit          gap_enable = 1'b1;
    event        hold_go;

    function automatic logic [31:0] fold_char(logic [31:0] h, logic [7:0] c);
        return {24'd0, c} + (h << 6) + (h << 16) - h;
    endfunction

    // Fold the lowercase hex text of v, no leading zeros, into h.
    function automatic logic [31:0] fold_hex(logic [31:0] h, logic [31:0] v);
        int top;
        logic [3:0] nib;
        top = 7;
        while (top > 0 && v[4*top +: 4] == 4'd0) top--;
        for (int k = top; k >= 0; k--) begin
            nib = v[4*k +: 4];
            h = fold_char(h, (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib}));
        end
        return h;
    endfunction

    // Advance the predictor by one accepted item.
    task automatic predict_item(t_in_item it);
        int n;
        int m;
        logic [31:0] a;
        logic [31:0] b;
        t_out_item res;
        case (it.action)
            ACT_BYTE: begin
                if (!open_terminated) begin
                    if (it.data_byte == 8'd0) open_terminated = 1'b1;
                    else open_hash = fold_char(open_hash, it.data_byte);
                end
            end
            ACT_CLOSE: begin
                if (stored_leaves < Leaves) begin
                    leaf_hashes[stored_leaves] = open_hash;
                    stored_leaves++;
                end else begin
                    dropped_leaf = 1'b1;
                end
                open_hash = '0;
                open_terminated = 1'b0;
            end
            ACT_FINISH: begin
                n = stored_leaves;
                while (n > 1) begin
                    m = 0;
                    for (int i = 0; i < n; i += 2) begin
                        a = leaf_hashes[i];
                        b = (i + 1 < n) ? leaf_hashes[i+1] : a;
                        leaf_hashes[m] = fold_hex(fold_hex(32'd0, a), b);
                        m++;
                    end
                    n = m;
                end
                res.root_hash = (n == 1) ? leaf_hashes[0] : 32'd0;
                res.empty_set = (stored_leaves == 0);
                res.overflow = dropped_leaf;
                root_queue = {root_queue, res};
                stored_leaves = 0;
                open_hash = '0;
                open_terminated = 1'b0;
                dropped_leaf = 1'b0;
            end
            default: ;
        endcase
    endtask

    // Offer one item with a random gap first; hold it until accepted.
    task automatic send_item(logic [1:0] act, logic [7:0] data);
        if (gap_enable && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_item.action <= act;
        in_item.data_byte <= data;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        predict_item('{action: act, data_byte: data});
        @(negedge i_clk);
    endtask

    task automatic send_leaf(int len);
        for (int i = 0; i < len; i++) send_item(ACT_BYTE, 8'($urandom_range(1, 255)));
        send_item(ACT_CLOSE, 8'd0);
    endtask

    task automatic test_extremes();
        send_item(ACT_FINISH, 8'd0);
        send_item(ACT_CLOSE, 8'd0);
        send_item(ACT_FINISH, 8'd0);
        send_item(ACT_BYTE, 8'hff);
        send_item(ACT_BYTE, 8'h01);
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BYTE, 8'haa);
        send_item(ACT_CLOSE, 8'd0);
        send_item(ACT_NONE, 8'h55);
        send_item(ACT_BYTE, 8'h80);
        send_item(ACT_CLOSE, 8'd0);
        send_item(ACT_BYTE, 8'h7f);
        send_item(ACT_CLOSE, 8'd0);
        send_item(ACT_BYTE, 8'h42);
        send_item(ACT_FINISH, 8'hff);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < Leaves + 2; i++) send_leaf($urandom_range(0, 2));
        send_item(ACT_FINISH, 8'd0);
    endtask

    task automatic test_random_sets();
        int budget;
        int k;
        budget = 950;
        while (budget > 0) begin
            k = $urandom_range(0, 9);
            if (k == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                    budget--;
                end
            end else begin
                repeat ($urandom_range(0, 12)) begin
                    k = $urandom_range(0, 5);
                    send_leaf(k);
                    budget -= k + 1;
                end
                send_item(ACT_FINISH, 8'($urandom));
                budget--;
            end
        end
    endtask

    // Long receiver hold-off while items keep coming.
    task automatic test_backpressure();
        gap_enable = 1'b0;
        -> hold_go;
        repeat (3) begin
            send_leaf(3);
            send_item(ACT_FINISH, 8'd0);
        end
        gap_enable = 1'b1;
    endtask

    // Hold-off counter, started on request.
    always begin
        @(hold_go);
        hold_cycles = 300;
        while (hold_cycles > 0) begin
            @(negedge i_clk);
            hold_cycles--;
        end
    end

    // Receiver stall pattern.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
        end else begin
            out_stall <= (cycles[7:6] == 2'b01) ? ($urandom_range(0, 1) == 0) : 1'b0;
        end
    end

    // Compare each accepted root against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (root_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected root %h", out_item);
            end else begin
                want = root_queue.pop_front();
                if (out_item.root_hash !== want.root_hash
                        || out_item.empty_set !== want.empty_set
                        || out_item.overflow !== want.overflow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("root mismatch: want %h/%b/%b got %h/%b/%b",
                            want.root_hash, want.empty_set, want.overflow,
                            out_item.root_hash, out_item.empty_set, out_item.overflow);
                end
            end
        end
    end

    // Cycle counter with timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_backpressure();
        test_overflow();
        test_random_sets();
        in_valid <= 1'b0;
        while (root_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && root_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
